FILE: hw/rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int CAP_W           = 5;
    localparam int DATA_W          = 32;
    localparam int HELD_W          = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] ITEM_EMPTY = -32'sd1;
    localparam logic signed [DATA_W-1:0] ITEM_NONE  = 32'sd0;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] item;
        logic [1:0]               status;
        logic [HELD_W-1:0]        entries_held;
    } rsp_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic                     ins_en;
        logic signed [DATA_W-1:0] value;
    } bcast_t;

endpackage

FILE: hw/rtl/spq_cell.sv
// one storage cell of the sorted chain
module spq_cell
(
    input  logic                             clk,
    input  spq_pkg::bcast_t                  bcast,
    input  logic                             occupied,
    input  logic                             at_fill,
    input  logic                             left_gt,
    input  logic signed [spq_pkg::DATA_W-1:0] left_entry,
    output logic                             gt,
    output logic signed [spq_pkg::DATA_W-1:0] entry
);

    logic signed [spq_pkg::DATA_W-1:0] entry_reg;
    logic signed [spq_pkg::DATA_W-1:0] entry_next;

    assign gt    = occupied && (entry_reg > bcast.value);
    assign entry = entry_reg;

    // everything above the insert point moves up one place
    always_comb
    begin
        entry_next = entry_reg;
        if (bcast.ins_en)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || at_fill)
            begin
                entry_next = bcast.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: control, result register and cell chain
// the done strobe comes in the cycle after the start transfer
// throughput: one request per cycle, busy stays low; every cell compares and
//   shifts in the same cycle, and a remove reads the top cell through one select
// reset: queue empty, capacity limit 16; cell contents are not cleared
// the receiver cannot stall, each result shows for exactly one cycle
module sorted_priority_queue
#(
    parameter int MAX_ENTRIES = spq_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  spq_pkg::req_t             req,
    output logic                      done,
    output spq_pkg::rsp_t             result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [spq_pkg::CAP_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [spq_pkg::CAP_W-1:0]     cap_reg;
    logic                          done_reg;
    spq_pkg::rsp_t                 rsp_reg;
    spq_pkg::rsp_t                 rsp_next;
    spq_pkg::bcast_t               bcast;
    logic                          accept;
    logic                          full;
    logic [LW-1:0]                 count_ext;

    logic                              gt_w    [MAX_ENTRIES];
    logic signed [spq_pkg::DATA_W-1:0] entry_w [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]            top_sel;
    logic signed [spq_pkg::DATA_W-1:0] top_entry;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign count_ext = LW'(count_reg);
    assign full      = (count_ext >= LW'(cap_reg)) || (count_ext >= LW'(MAX_ENTRIES));

    assign bcast.ins_en = accept && (req.op == spq_pkg::OP_INSERT) && !full;
    assign bcast.value  = req.value;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            logic                              lgt;
            logic signed [spq_pkg::DATA_W-1:0] lent;
            if (gi == 0)
            begin : g_first
                assign lgt  = 1'b0;
                assign lent = bcast.value;
            end
            else
            begin : g_rest
                assign lgt  = gt_w[gi-1];
                assign lent = entry_w[gi-1];
            end
            spq_cell u_cell
            (
                .clk        (clk),
                .bcast      (bcast),
                .occupied   (count_reg > CW'(gi)),
                .at_fill    (count_reg == CW'(gi)),
                .left_gt    (lgt),
                .left_entry (lent),
                .gt         (gt_w[gi]),
                .entry      (entry_w[gi])
            );
            assign top_sel[gi] = (count_reg == CW'(gi + 1));
        end
    endgenerate

    // the top cell is the one just below the fill count
    always_comb
    begin
        top_entry = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            top_entry = top_entry | (entry_w[i] & {spq_pkg::DATA_W{top_sel[i]}});
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        rsp_next.item   = spq_pkg::ITEM_NONE;
        rsp_next.status = spq_pkg::ST_DONE;
        if (req.op == spq_pkg::OP_INSERT)
        begin
            if (full)
            begin
                rsp_next.status = spq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                rsp_next.item   = spq_pkg::ITEM_EMPTY;
                rsp_next.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                count_next    = count_reg - CW'(1);
                rsp_next.item = top_entry;
            end
        end
        rsp_next.entries_held = spq_pkg::HELD_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= spq_pkg::CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

FILE: hw/rtl/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input spq_pkg::req_t             req,
    input logic                      done,
    input spq_pkg::rsp_t             result,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [spq_pkg::CAP_W-1:0] cfg_data
);

    // every accepted request gives exactly one result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && start && !busy |=> done)
        else $error("no result after accepted request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without request");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == spq_pkg::ST_EMPTY) |->
        (result.item == spq_pkg::ITEM_EMPTY) && (result.entries_held == '0))
        else $error("empty status with wrong item or count");

    // a zero capacity rejects inserts even into an empty queue
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == spq_pkg::ST_FULL) |->
        (result.item == spq_pkg::ITEM_NONE))
        else $error("full status with wrong item");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

FILE: tb/sv/tb_sorted_priority_queue.sv
// self-checking testbench for the sorted priority queue: directed corners, then random traffic
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    localparam int DEPTH = spq_pkg::MAX_ENTRIES_DEF;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    logic                      busy;
    spq_pkg::req_t             req       = '0;
    logic                      done;
    spq_pkg::rsp_t             result;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [spq_pkg::CAP_W-1:0] cfg_data  = '0;

    // software copy of the queue contents and the capacity register
    logic signed [spq_pkg::DATA_W-1:0] shadow_entries [DEPTH];
    int unsigned                       shadow_fill;
    logic [spq_pkg::CAP_W-1:0]         shadow_cap;

    spq_pkg::rsp_t expected_rsp [$];
    spq_pkg::rsp_t head_rsp;
    int            error_count = 0;

    sorted_priority_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("sorted_priority_queue verification failed");
        $finish;
    end

    // applies one request to the shadow queue and returns the response it must produce
    function automatic spq_pkg::rsp_t apply_request(spq_pkg::req_t r);
        spq_pkg::rsp_t p;
        int unsigned   lim;
        int unsigned   pos;
        p.item   = spq_pkg::ITEM_NONE;
        p.status = spq_pkg::ST_DONE;
        lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        if (r.op == spq_pkg::OP_INSERT)
        begin
            if (shadow_fill >= lim)
                p.status = spq_pkg::ST_FULL;
            else
            begin
                // larger values move up, the new one lands after its equals
                pos = shadow_fill;
                while (pos > 0 && shadow_entries[pos-1] > r.value)
                begin
                    shadow_entries[pos] = shadow_entries[pos-1];
                    pos--;
                end
                shadow_entries[pos] = r.value;
                shadow_fill++;
            end
        end
        else if (shadow_fill == 0)
        begin
            p.item   = spq_pkg::ITEM_EMPTY;
            p.status = spq_pkg::ST_EMPTY;
        end
        else
        begin
            shadow_fill--;
            p.item = shadow_entries[shadow_fill];
        end
        p.entries_held = shadow_fill[spq_pkg::HELD_W-1:0];
        return p;
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return $signed($urandom_range(0, 6)) - 32'sd3;
            4:       return 32'h8000_0000 | $urandom_range(0, 3);
            5:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(logic op, logic signed [spq_pkg::DATA_W-1:0] value,
                                bit no_idle);
        int gap;
        spq_pkg::req_t r;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.op    = op;
        r.value = value;
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        // transfer taken at this edge
        expected_rsp.push_back(apply_request(r));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(logic [spq_pkg::CAP_W-1:0] cap);
        wait_idle();
        repeat (pick_gap()) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        shadow_cap  = cap;
    endtask

    task automatic test_empty_and_extremes();
        send_request(spq_pkg::OP_REMOVE, 32'sd0, 1'b0);      // empty queue
        send_request(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 1'b0);
        send_request(spq_pkg::OP_INSERT, 32'sh8000_0000, 1'b1);
        send_request(spq_pkg::OP_INSERT, 32'sd0, 1'b1);
        send_request(spq_pkg::OP_INSERT, -32'sd1, 1'b0);
        send_request(spq_pkg::OP_INSERT, 32'sd7, 1'b1);
        send_request(spq_pkg::OP_INSERT, 32'sd7, 1'b1);
        send_request(spq_pkg::OP_REMOVE, $urandom(), 1'b1);
        send_request(spq_pkg::OP_REMOVE, $urandom(), 1'b0);
        send_request(spq_pkg::OP_REMOVE, $urandom(), 1'b1);
    endtask

    task automatic test_capacity_below_fill();
        write_capacity(5'd2);
        send_request(spq_pkg::OP_INSERT, 32'sd3, 1'b0);      // rejected, fill is over the limit
        repeat (5) send_request(spq_pkg::OP_REMOVE, $urandom(), 1'b1);
    endtask

    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_request(spq_pkg::OP_INSERT, -32'sd5, 1'b0);
        send_request(spq_pkg::OP_REMOVE, 32'sd0, 1'b1);
    endtask

    task automatic random_phase(logic [spq_pkg::CAP_W-1:0] cap, int count);
        int  sent;
        int  burst_len;
        bit  fill_up;
        bit  no_idle;
        logic op;
        write_capacity(cap);
        sent = 0;
        while (sent < count)
        begin
            // bursts that lean one way reach both full and empty
            burst_len = $urandom_range(1, 24);
            fill_up   = $urandom_range(0, 1);
            no_idle   = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < burst_len && sent < count; i++)
            begin
                if ($urandom_range(0, 9) < 8)
                    op = fill_up ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
                else
                    op = fill_up ? spq_pkg::OP_REMOVE : spq_pkg::OP_INSERT;
                send_request(op, pick_value(), no_idle);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(5'd16, 200);
        random_phase(5'd1, 190);
        random_phase(5'd31, 200);
        random_phase(5'd0, 120);
        random_phase(5'd3, 190);
        random_phase(5'd17, 200);
        random_phase(5'd8, 190);
        random_phase(5'd2, 190);
        random_phase(5'($urandom_range(1, 16)), 190);
        random_phase(5'd16, 200);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result with no request pending: item %0d status %0d held %0d",
                       result.item, result.status, result.entries_held);
                error_count++;
            end
            else
            begin
                head_rsp = expected_rsp.pop_front();
                if (result.item !== head_rsp.item)
                begin
                    $error("item: expected %0d, got %0d", head_rsp.item, result.item);
                    error_count++;
                end
                if (result.status !== head_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", head_rsp.status, result.status);
                    error_count++;
                end
                if (result.entries_held !== head_rsp.entries_held)
                begin
                    $error("entries_held: expected %0d, got %0d",
                           head_rsp.entries_held, result.entries_held);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        shadow_fill = 0;
        shadow_cap  = spq_pkg::CAP_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_capacity_below_fill();
        test_capacity_zero();
        test_random_traffic();

        wait_idle();
        repeat (4) @(posedge clk);
        if (error_count == 0 && expected_rsp.size() == 0)
            $display("sorted_priority_queue verification clean");
        else
            $display("sorted_priority_queue verification failed");
        $finish;
    end

endmodule
